### rtl/reliable_stream_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// reliable_stream_receiver_top_macros.svh
// assertion macros shared by the receiver checks
// ----------------------------------------------------------------------------
`ifndef RELIABLE_STREAM_RECEIVER_TOP_MACROS_SVH
`define RELIABLE_STREAM_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define RSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rsr_pkg.sv
// ----------------------------------------------------------------------------
// rsr_pkg
// types and constants of the reliable stream receiver
// ----------------------------------------------------------------------------
`default_nettype none

package rsr_pkg;

	localparam int unsigned CFG_IDX_W     = 8;
	localparam int unsigned CFG_DATA_W    = 32;

	localparam logic [7:0]  MAGIC_BYTE    = 8'h45;
	localparam logic [7:0]  FLAG_DATA     = 8'h01;
	localparam logic [15:0] MAX_FRAME     = 16'd4095;
	localparam logic [15:0] HDR_END       = 16'd62;
	localparam logic [7:0]  TIMEOUT_RESET = 8'd10;
	localparam logic [7:0]  IDLE_MAX      = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LENGTH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 8'd1;

	typedef enum logic [1:0] {
		KIND_FRAME = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_START = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_ACCEPTED  = 4'd0,
		ST_SHORT     = 4'd1,
		ST_BAD_MAGIC = 4'd2,
		ST_NOT_DATA  = 4'd3,
		ST_TRUNCATED = 4'd4,
		ST_DUPLICATE = 4'd5,
		ST_EARLY     = 4'd6,
		ST_TIMEOUT   = 4'd7,
		ST_IGNORED   = 4'd8,
		ST_OVERSIZE  = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		RK_NONE   = 2'd0,
		RK_ACK    = 2'd1,
		RK_RESEND = 2'd2
	} reply_kind_t;

endpackage

`default_nettype wire

### rtl/reliable_stream_receiver_top.sv
// ----------------------------------------------------------------------------
// reliable_stream_receiver_top
// in-order receiver for a sequenced frame stream with ack and resend replies
// ----------------------------------------------------------------------------
// One item (parsed frame header, timer tick or session start) is taken per
// clock unless a result waits on out_ready, and gives exactly one result.
// An accepted item is held in the input register, where a single pass of
// compare and add logic reads and updates the session state; the result
// register is loaded as the item moves on. The state update
// happens as the item leaves the input register, so back-to-back items see
// each other's effects. Configuration writes are taken every cycle and must
// only be issued while no item is in flight.
`default_nettype none

module reliable_stream_receiver_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rsr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      kind,
	input  wire logic [15:0]                     frame_len,
	input  wire logic [7:0]                      magic,
	input  wire logic [7:0]                      flags,
	input  wire logic [15:0]                     payload_len,
	input  wire logic [31:0]                     seq,
	input  wire logic [47:0]                     src_mac,
	input  wire logic [47:0]                     dst_mac,
	input  wire logic [31:0]                     src_ip,
	input  wire logic [31:0]                     dst_ip,
	input  wire logic [15:0]                     src_port,
	input  wire logic [15:0]                     dst_port,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [3:0]                           status,
	output logic [1:0]                           reply_kind,
	output logic [31:0]                          reply_seq,
	output logic [31:0]                          write_offset,
	output logic [15:0]                          accepted_len,
	output logic                                 done_res,
	output logic [47:0]                          peer_mac_out,
	output logic [47:0]                          local_mac_out,
	output logic [31:0]                          peer_ip_out,
	output logic [31:0]                          local_ip_out,
	output logic [15:0]                          peer_port_out,
	output logic [15:0]                          local_port_out
);

	import rsr_pkg::*;

	// configuration
	logic [31:0] stream_length_q;
	logic [7:0]  timeout_ticks_q;

	// input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [15:0] frame_len_s1;
	logic [7:0]  magic_s1;
	logic [7:0]  flags_s1;
	logic [15:0] payload_len_s1;
	logic [31:0] seq_s1;
	logic [47:0] src_mac_s1;
	logic [47:0] dst_mac_s1;
	logic [31:0] src_ip_s1;
	logic [31:0] dst_ip_s1;
	logic [15:0] src_port_s1;
	logic [15:0] dst_port_s1;

	// session state
	logic [31:0] next_expected_q;
	logic [31:0] progress_mark_q;
	logic [7:0]  idle_count_q;
	logic        active_q;
	logic [47:0] far_mac_q;
	logic [47:0] near_mac_q;
	logic [31:0] far_ip_q;
	logic [31:0] near_ip_q;
	logic [15:0] far_port_q;
	logic [15:0] near_port_q;

	logic [31:0] n_next_expected;
	logic [31:0] n_progress_mark;
	logic [7:0]  n_idle_count;
	logic        n_active;
	logic [47:0] n_far_mac;
	logic [47:0] n_near_mac;
	logic [31:0] n_far_ip;
	logic [31:0] n_near_ip;
	logic [15:0] n_far_port;
	logic [15:0] n_near_port;

	// result
	status_t     r_status;
	reply_kind_t r_kind;
	logic [31:0] r_seq;
	logic [31:0] r_woff;
	logic [15:0] r_alen;
	logic        r_done;

	logic [31:0] seq_end;
	logic [16:0] hdr_need;
	logic [31:0] exp_sum;
	logic [7:0]  idle_inc;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	reply_kind_t reply_kind_q;
	logic [31:0] reply_seq_q;
	logic [31:0] write_offset_q;
	logic [15:0] accepted_len_q;
	logic        done_q;

	logic        advance_s1;

	assign cfg_ready  = 1'b1;
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= '0;
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_STREAM_LENGTH) begin
				stream_length_q <= cfg_data;
			end else if (cfg_index == CFG_TIMEOUT_TICKS) begin
				timeout_ticks_q <= cfg_data[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1        <= kind;
			frame_len_s1   <= frame_len;
			magic_s1       <= magic;
			flags_s1       <= flags;
			payload_len_s1 <= payload_len;
			seq_s1         <= seq;
			src_mac_s1     <= src_mac;
			dst_mac_s1     <= dst_mac;
			src_ip_s1      <= src_ip;
			dst_ip_s1      <= dst_ip;
			src_port_s1    <= src_port;
			dst_port_s1    <= dst_port;
		end
	end

	always_comb begin
		n_next_expected = next_expected_q;
		n_progress_mark = progress_mark_q;
		n_idle_count    = idle_count_q;
		n_active        = active_q;
		n_far_mac       = far_mac_q;
		n_near_mac      = near_mac_q;
		n_far_ip        = far_ip_q;
		n_near_ip       = near_ip_q;
		n_far_port      = far_port_q;
		n_near_port     = near_port_q;
		r_status        = ST_IGNORED;
		r_kind          = RK_NONE;
		r_seq           = '0;
		r_woff          = '0;
		r_alen          = '0;
		r_done          = 1'b0;

		seq_end  = seq_s1 + {16'h0, payload_len_s1};
		hdr_need = {1'b0, HDR_END} + {1'b0, payload_len_s1};
		exp_sum  = next_expected_q + {16'h0, payload_len_s1};
		idle_inc = (idle_count_q == IDLE_MAX) ? idle_count_q : idle_count_q + 8'd1;

		case (kind_s1)
			KIND_START: begin
				n_next_expected = '0;
				n_progress_mark = '0;
				n_idle_count    = '0;
				n_active        = 1'b1;
				n_far_mac       = '0;
				n_near_mac      = '0;
				n_far_ip        = '0;
				n_near_ip       = '0;
				n_far_port      = '0;
				n_near_port     = '0;
				r_status        = ST_ACCEPTED;
				if (stream_length_q == '0) begin
					n_active = 1'b0;
					r_done   = 1'b1;
				end
			end
			KIND_TICK: begin
				if (active_q) begin
					r_status = ST_ACCEPTED;
					if (progress_mark_q == next_expected_q) begin
						n_idle_count = idle_inc;
						if (idle_inc >= timeout_ticks_q) begin
							r_status     = ST_TIMEOUT;
							r_kind       = RK_RESEND;
							r_seq        = next_expected_q;
							n_idle_count = '0;
						end
					end else begin
						n_progress_mark = next_expected_q;
						n_idle_count    = '0;
					end
				end
			end
			KIND_FRAME: begin
				if (active_q) begin
					if (frame_len_s1 > MAX_FRAME) begin
						r_status = ST_OVERSIZE;
						n_active = 1'b0;
						r_done   = 1'b1;
					end else if (frame_len_s1 == '0) begin
						r_status = ST_IGNORED;
					end else if (frame_len_s1 < HDR_END) begin
						r_status = ST_SHORT;
					end else if (magic_s1 != MAGIC_BYTE) begin
						r_status = ST_BAD_MAGIC;
					end else if (flags_s1 != FLAG_DATA) begin
						r_status = ST_NOT_DATA;
					end else begin
						n_far_mac   = src_mac_s1;
						n_near_mac  = dst_mac_s1;
						n_far_ip    = src_ip_s1;
						n_near_ip   = dst_ip_s1;
						n_far_port  = src_port_s1;
						n_near_port = dst_port_s1;
						if ({1'b0, frame_len_s1} < hdr_need) begin
							r_status = ST_TRUNCATED;
						end else if (seq_end <= next_expected_q) begin
							r_status = ST_DUPLICATE;
							r_kind   = RK_ACK;
							r_seq    = next_expected_q;
						end else if (seq_s1 == next_expected_q) begin
							r_status        = ST_ACCEPTED;
							r_woff          = next_expected_q;
							r_alen          = payload_len_s1;
							n_next_expected = exp_sum;
							r_kind          = RK_ACK;
							r_seq           = exp_sum;
							if (exp_sum >= stream_length_q) begin
								n_active = 1'b0;
								r_done   = 1'b1;
							end
						end else begin
							r_status = ST_EARLY;
							r_kind   = RK_RESEND;
							r_seq    = next_expected_q;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_expected_q <= '0;
			progress_mark_q <= '0;
			idle_count_q    <= '0;
			active_q        <= 1'b0;
			far_mac_q       <= '0;
			near_mac_q      <= '0;
			far_ip_q        <= '0;
			near_ip_q       <= '0;
			far_port_q      <= '0;
			near_port_q     <= '0;
		end else if (advance_s1) begin
			next_expected_q <= n_next_expected;
			progress_mark_q <= n_progress_mark;
			idle_count_q    <= n_idle_count;
			active_q        <= n_active;
			far_mac_q       <= n_far_mac;
			near_mac_q      <= n_near_mac;
			far_ip_q        <= n_far_ip;
			near_ip_q       <= n_near_ip;
			far_port_q      <= n_far_port;
			near_port_q     <= n_near_port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			status_q       <= r_status;
			reply_kind_q   <= r_kind;
			reply_seq_q    <= r_seq;
			write_offset_q <= r_woff;
			accepted_len_q <= r_alen;
			done_q         <= r_done;
		end
	end

	// addressing outputs show the state after the item just delivered
	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign reply_kind     = reply_kind_q;
	assign reply_seq      = reply_seq_q;
	assign write_offset   = write_offset_q;
	assign accepted_len   = accepted_len_q;
	assign done_res       = done_q;
	assign peer_mac_out   = far_mac_q;
	assign local_mac_out  = near_mac_q;
	assign peer_ip_out    = far_ip_q;
	assign local_ip_out   = near_ip_q;
	assign peer_port_out  = far_port_q;
	assign local_port_out = near_port_q;

endmodule

`default_nettype wire

### rtl/rsr_checker.sv
// ----------------------------------------------------------------------------
// rsr_checker
// port-level checks on the reliable stream receiver results
// ----------------------------------------------------------------------------
`default_nettype none

`include "reliable_stream_receiver_top_macros.svh"

module rsr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  status,
	input wire logic [1:0]  reply_kind,
	input wire logic [31:0] reply_seq,
	input wire logic [31:0] write_offset,
	input wire logic [15:0] accepted_len,
	input wire logic        done_res
);

	import rsr_pkg::*;

	`RSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(reply_seq), "result changed while stalled")
	`RSR_ASSERT_NOW(a_done_cause, clk, arst_n, out_valid && done_res, status == ST_ACCEPTED || status == ST_OVERSIZE, "session closed by wrong status")
	`RSR_ASSERT_NOW(a_resend_cause, clk, arst_n, out_valid && reply_kind == RK_RESEND, status == ST_EARLY || status == ST_TIMEOUT, "resend without early or timeout")
	`RSR_ASSERT_NOW(a_dup_ack, clk, arst_n, out_valid && status == ST_DUPLICATE, reply_kind == RK_ACK && accepted_len == '0, "duplicate not acked")
	`RSR_ASSERT_NOW(a_accept_ack, clk, arst_n, out_valid && accepted_len != '0, status == ST_ACCEPTED && reply_kind == RK_ACK && reply_seq == write_offset + {16'h0, accepted_len}, "ack does not follow accepted data")

endmodule

bind reliable_stream_receiver_top rsr_checker u_rsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.reply_kind   (reply_kind),
	.reply_seq    (reply_seq),
	.write_offset (write_offset),
	.accepted_len (accepted_len),
	.done_res     (done_res)
);

`default_nettype wire
